>>> rtl/core/pfr_pkg.sv
// Package: shared types, codes and constants for the page frame replacement block
`default_nettype none
package pfr_pkg;

    localparam int PAGE_W         = 20;
    localparam int FIDX_W         = 4;
    localparam int LFSR_W         = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int FIU_W          = 5;
    localparam int FRAMES_DEF     = 16;
    localparam int STAMP_BITS_DEF = 32;

    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
    localparam logic [FIU_W-1:0]  FIU_RESET  = 5'd16;

    typedef enum logic [1:0] {
        POL_RANDOM = 2'd0,
        POL_FIFO   = 2'd1,
        POL_LRU    = 2'd2,
        POL_CLOCK  = 2'd3
    } policy_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POLICY = 2'd0,
        CFG_FRAMES = 2'd1,
        CFG_SEED   = 2'd2,
        CFG_SPARE  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        CLR_NONE = 2'd0,
        CLR_SPAN = 2'd1,
        CLR_WRAP = 2'd2,
        CLR_ALL  = 2'd3
    } clr_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MOD,
        ST_APPLY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              valid;
        logic              dirty;
        logic              ref_bit;
    } frame_flags_t;

endpackage
`default_nettype wire

>>> rtl/core/page_frame_replacement.sv
// Top level: page frame replacement unit built as a rotating row of frame cells
//
// Usage:
//   Input channel (in_valid / in_stall) carries one access word: access_page and
//   is_write. Output channel (out_valid / out_stall) returns one result word per
//   access: hit, frame_index, evicted, evicted_page, writeback.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_data while idle;
//   a seed write reloads the random-mode LFSR at once.
//   Sequence: one full rotation of the cell row to search, a decide step, one
//   full rotation to update and a load of the output register; a random
//   eviction first runs the bit-serial remainder unit before the update.
//   The block returns to idle after the load and then takes the next access.
//   The block works on one access at a time and takes the next access while
//   the previous result still waits in the output register.
//   Reset clears every valid, dirty and reference bit, the clock hand, the stamp
//   counter and the fill count, and loads the LFSR with its reset seed.
//   While the receiver stalls, the result word holds; a finished access waits
//   in its last state until the output register is free.
`default_nettype none
module page_frame_replacement
    import pfr_pkg::*;
#(
    parameter int FRAMES     = FRAMES_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [PAGE_W-1:0]      access_page,
    input  wire logic                   is_write,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        hit,
    output logic [FIDX_W-1:0]           frame_index,
    output logic                        evicted,
    output logic [PAGE_W-1:0]           evicted_page,
    output logic                        writeback
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES+1);

    // configuration
    policy_t          policy_reg;
    logic [FIU_W-1:0] fiu_reg;
    logic [LFSR_W-1:0] lfsr_reg;
    logic [CNT_W-1:0] n_act;

    // control
    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg;
    logic             idx_last;
    logic             in_range;
    logic             in_take;
    logic             go_apply;
    logic             out_load;

    // access context
    logic [PAGE_W-1:0]     page_reg;
    logic                  wr_reg;
    logic [IDX_W-1:0]      h0_reg;
    logic [IDX_W-1:0]      hand_reg;
    logic [STAMP_BITS-1:0] stamp_cnt_reg;
    logic [STAMP_BITS-1:0] stamp_val_reg;
    logic [CNT_W-1:0]      filled_reg;

    // search results
    logic                  hit_found_reg, free_found_reg, hi_found_reg, any_found_reg;
    logic [IDX_W-1:0]      hit_idx_reg, free_idx_reg, hi_idx_reg, any_idx_reg, min_idx_reg;
    logic [STAMP_BITS-1:0] min_stamp_reg;

    // decision
    logic [IDX_W-1:0] f_reg;
    logic             evict_reg;
    clr_kind_t        clr_reg;
    logic [IDX_W-1:0] clk_victim;
    logic [LFSR_W-1:0] lfsr_step;
    logic             rem_start;
    logic             rem_done;
    logic [IDX_W-1:0] rem_value;

    // captured victim
    logic [PAGE_W-1:0] old_page_reg;
    logic              old_dirty_reg;

    // output register
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [FIDX_W-1:0] out_fidx_reg;
    logic              out_evict_reg;
    logic [PAGE_W-1:0] out_page_reg;
    logic              out_wb_reg;

    // cell row
    frame_flags_t          flags_q [FRAMES];
    logic [STAMP_BITS-1:0] stamp_q [FRAMES];
    frame_flags_t          head_flags;
    logic [STAMP_BITS-1:0] head_stamp;
    logic                  shift;
    logic                  ge_h0, lt_f, clr_hit;

    // clamp the frame count to 1..FRAMES
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (32'(fiu_reg) > FRAMES)
        begin
            n_act = CNT_W'(FRAMES);
        end
        else
        begin
            n_act = CNT_W'(fiu_reg);
        end
    end

    assign idx_last  = (idx_reg == IDX_W'(FRAMES-1));
    assign in_range  = (CNT_W'(idx_reg) < n_act);
    assign in_take   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign shift     = (state_reg == ST_SCAN) || (state_reg == ST_APPLY);
    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
    assign clk_victim = hi_found_reg ? hi_idx_reg : (any_found_reg ? any_idx_reg : h0_reg);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // build the cell row; the last cell takes the possibly updated head
    for (genvar k = 0; k < FRAMES; k++)
    begin : g_cell
        frame_flags_t          nb_flags;
        logic [STAMP_BITS-1:0] nb_stamp;
        if (k == FRAMES-1)
        begin : g_tail
            assign nb_flags = head_flags;
            assign nb_stamp = head_stamp;
        end
        else
        begin : g_mid
            assign nb_flags = flags_q[k+1];
            assign nb_stamp = stamp_q[k+1];
        end
        pfr_cell #(
            .STAMP_BITS (STAMP_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (shift),
            .flags_in  (nb_flags),
            .stamp_in  (nb_stamp),
            .flags_out (flags_q[k]),
            .stamp_out (stamp_q[k])
        );
    end

    // update the head frame as it passes during the apply rotation
    assign ge_h0 = (idx_reg >= h0_reg);
    assign lt_f  = (idx_reg < f_reg);
    always_comb
    begin
        case (clr_reg)
            CLR_SPAN: clr_hit = ge_h0 && lt_f;
            CLR_WRAP: clr_hit = ge_h0 || lt_f;
            CLR_ALL:  clr_hit = 1'b1;
            default:  clr_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        head_flags = flags_q[0];
        head_stamp = stamp_q[0];
        if ((state_reg == ST_APPLY) && in_range)
        begin
            if (clr_hit)
            begin
                head_flags.ref_bit = 1'b0;
            end
            if (idx_reg == f_reg)
            begin
                if (hit_found_reg)
                begin
                    head_flags.ref_bit = 1'b1;
                    head_flags.dirty   = flags_q[0].dirty | wr_reg;
                    if (policy_reg != POL_FIFO)
                    begin
                        head_stamp = stamp_val_reg;
                    end
                end
                else
                begin
                    head_flags.page    = page_reg;
                    head_flags.valid   = 1'b1;
                    head_flags.dirty   = wr_reg;
                    head_flags.ref_bit = 1'b1;
                    head_stamp         = stamp_val_reg;
                end
            end
        end
    end

    pfr_rem #(
        .FRAMES (FRAMES)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (lfsr_step),
        .divisor   (n_act),
        .done      (rem_done),
        .remainder (rem_value)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        rem_start  = 1'b0;
        go_apply   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!hit_found_reg && !free_found_reg && (policy_reg == POL_RANDOM))
                begin
                    rem_start  = 1'b1;
                    state_next = ST_MOD;
                end
                else
                begin
                    go_apply   = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_MOD:
            begin
                if (rem_done)
                begin
                    go_apply   = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (idx_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration, LFSR, hand, stamp counter, fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_LRU;
            fiu_reg       <= FIU_RESET;
            lfsr_reg      <= SEED_RESET;
            hand_reg      <= '0;
            stamp_cnt_reg <= '0;
            filled_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_POLICY: policy_reg <= policy_t'(cfg_data[1:0]);
                    CFG_FRAMES: fiu_reg    <= cfg_data[FIU_W-1:0];
                    CFG_SEED:   lfsr_reg   <= cfg_data[LFSR_W-1:0];
                    default:    ;
                endcase
            end
            else if (rem_start)
            begin
                lfsr_reg <= lfsr_step;
            end
            if ((state_reg == ST_DECIDE) && !hit_found_reg && !free_found_reg
                && (policy_reg == POL_CLOCK))
            begin
                if (CNT_W'(clk_victim) + 1'b1 < n_act)
                begin
                    hand_reg <= clk_victim + 1'b1;
                end
                else
                begin
                    hand_reg <= '0;
                end
            end
            if ((state_reg == ST_DECIDE) && !hit_found_reg && free_found_reg
                && (filled_reg < CNT_W'(FRAMES)))
            begin
                filled_reg <= filled_reg + 1'b1;
            end
            if (go_apply && !(hit_found_reg && (policy_reg == POL_FIFO)))
            begin
                stamp_cnt_reg <= stamp_cnt_reg + 1'b1;
            end
        end
    end

    // rotation index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (shift)
        begin
            idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
        end
    end

    // access context and search results
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            page_reg       <= access_page;
            wr_reg         <= is_write;
            h0_reg         <= (CNT_W'(hand_reg) < n_act) ? hand_reg : '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            hi_found_reg   <= 1'b0;
            any_found_reg  <= 1'b0;
        end
        else if ((state_reg == ST_SCAN) && in_range)
        begin
            if (flags_q[0].valid && (flags_q[0].page == page_reg) && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= idx_reg;
            end
            if (!flags_q[0].valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            if ((idx_reg == '0) || (stamp_q[0] < min_stamp_reg))
            begin
                min_stamp_reg <= stamp_q[0];
                min_idx_reg   <= idx_reg;
            end
            if (!flags_q[0].ref_bit)
            begin
                if (!any_found_reg)
                begin
                    any_found_reg <= 1'b1;
                    any_idx_reg   <= idx_reg;
                end
                if (ge_h0 && !hi_found_reg)
                begin
                    hi_found_reg <= 1'b1;
                    hi_idx_reg   <= idx_reg;
                end
            end
        end
    end

    // pick the target frame
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECIDE)
        begin
            evict_reg <= !hit_found_reg && !free_found_reg;
            clr_reg   <= CLR_NONE;
            if (hit_found_reg)
            begin
                f_reg <= hit_idx_reg;
            end
            else if (free_found_reg)
            begin
                f_reg <= free_idx_reg;
            end
            else if (policy_reg == POL_CLOCK)
            begin
                f_reg <= clk_victim;
                if (hi_found_reg)
                begin
                    clr_reg <= CLR_SPAN;
                end
                else if (any_found_reg)
                begin
                    clr_reg <= CLR_WRAP;
                end
                else
                begin
                    clr_reg <= CLR_ALL;
                end
            end
            else
            begin
                f_reg <= min_idx_reg;
            end
        end
        else if ((state_reg == ST_MOD) && rem_done)
        begin
            f_reg <= rem_value;
        end
        if (go_apply)
        begin
            stamp_val_reg <= stamp_cnt_reg;
        end
        // capture the victim before it is overwritten
        if ((state_reg == ST_APPLY) && (idx_reg == f_reg))
        begin
            old_page_reg  <= evict_reg ? flags_q[0].page : '0;
            old_dirty_reg <= evict_reg ? flags_q[0].dirty : 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg   <= hit_found_reg;
            out_fidx_reg  <= FIDX_W'(f_reg);
            out_evict_reg <= evict_reg;
            out_page_reg  <= old_page_reg;
            out_wb_reg    <= old_dirty_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = out_hit_reg;
    assign frame_index  = out_fidx_reg;
    assign evicted      = out_evict_reg;
    assign evicted_page = out_page_reg;
    assign writeback    = out_wb_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CNT_W'(FRAMES))
        else $error("fill count past frame count");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted)
        else $error("hit reported with eviction");

    a_no_evict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> (evicted_page == '0) && !writeback)
        else $error("victim fields set without eviction");

    a_idle_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (idx_reg == '0))
        else $error("cell row not aligned while idle");

    a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("finished access not presented");
`endif

endmodule
`default_nettype wire

>>> rtl/core/pfr_cell.sv
// One frame cell of the rotating frame table
`default_nettype none
module pfr_cell
    import pfr_pkg::*;
#(
    parameter int STAMP_BITS = STAMP_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  shift,
    input  wire frame_flags_t          flags_in,
    input  wire logic [STAMP_BITS-1:0] stamp_in,
    output frame_flags_t               flags_out,
    output logic [STAMP_BITS-1:0]      stamp_out
);

    logic                  valid_reg;
    logic                  dirty_reg;
    logic                  ref_reg;
    logic [PAGE_W-1:0]     page_reg;
    logic [STAMP_BITS-1:0] stamp_reg;

    // take the neighbor's control bits on a shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            ref_reg   <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= flags_in.valid;
            dirty_reg <= flags_in.dirty;
            ref_reg   <= flags_in.ref_bit;
        end
    end

    // take the neighbor's page and stamp on a shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            page_reg  <= flags_in.page;
            stamp_reg <= stamp_in;
        end
    end

    assign flags_out.page    = page_reg;
    assign flags_out.valid   = valid_reg;
    assign flags_out.dirty   = dirty_reg;
    assign flags_out.ref_bit = ref_reg;
    assign stamp_out         = stamp_reg;

endmodule
`default_nettype wire

>>> rtl/core/pfr_rem.sv
// Bit-serial remainder of the LFSR value by the active frame count
`default_nettype none
module pfr_rem
    import pfr_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [LFSR_W-1:0]            dividend,
    input  wire logic [$clog2(FRAMES+1)-1:0]  divisor,
    output logic                              done,
    output logic [((FRAMES>1)?$clog2(FRAMES):1)-1:0] remainder
);

    localparam int CNT_W  = $clog2(FRAMES+1);
    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int STEP_W = $clog2(LFSR_W+1);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [LFSR_W-1:0] dvd_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W:0]    trial;

    // shift in one dividend bit, subtract when it fits
    assign trial = {rem_reg, dvd_reg[LFSR_W-1]};
    assign done  = busy_reg && (step_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(LFSR_W);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg && (step_reg != '0))
        begin
            dvd_reg <= {dvd_reg[LFSR_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_reg <= CNT_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_reg <= CNT_W'(trial);
            end
        end
    end

    assign remainder = IDX_W'(rem_reg);

endmodule
`default_nettype wire

>>> dv/page_frame_replacement_tb.sv
// Testbench for the page frame replacement unit: accesses checked against a predictor
`timescale 1ns / 100ps
`default_nettype none

module page_frame_replacement_tb
    import pfr_pkg::*;
;

    localparam int NFR = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic              hit;
        logic [FIDX_W-1:0] frame_index;
        logic              evicted;
        logic [PAGE_W-1:0] evicted_page;
        logic              writeback;
    } access_result_t;

    // Frame table predictor and store of expected result words
    class frame_table_scoreboard;
        policy_t           pol;
        logic [FIU_W-1:0]  fiu;
        logic [15:0]       lfsr;
        logic [PAGE_W-1:0] pg [NFR];
        bit                vld [NFR];
        bit                drt [NFR];
        bit                rfb [NFR];
        logic [31:0]       stp [NFR];
        int unsigned       hand;
        logic [31:0]       stamp_ctr;
        access_result_t    pending [$];
        int                errors;

        function void reset_state();
            pol = POL_LRU;
            fiu = FIU_RESET;
            lfsr = SEED_RESET;
            for (int i = 0; i < NFR; i++)
            begin
                vld[i] = 0; drt[i] = 0; rfb[i] = 0; pg[i] = '0; stp[i] = '0;
            end
            hand = 0;
            stamp_ctr = '0;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] val);
            case (idx)
                CFG_POLICY: pol = policy_t'(val[1:0]);
                CFG_FRAMES: fiu = val[4:0];
                CFG_SEED:   lfsr = val;
                default: ;
            endcase
        endfunction

        function void note_access(logic [PAGE_W-1:0] page, logic wr);
            access_result_t r;
            int unsigned n, f, h;
            bit found;
            n = (fiu == 0) ? 1 : ((fiu > NFR) ? NFR : fiu);
            r = '{0, 0, 0, 0, 0};
            f = 0;
            found = 0;
            for (int i = 0; i < n; i++)
                if (!found && vld[i] && pg[i] == page)
                begin
                    found = 1; f = i;
                end
            if (found)
            begin
                r.hit = 1;
                if (pol != POL_FIFO)
                begin
                    stp[f] = stamp_ctr; stamp_ctr++;
                end
                rfb[f] = 1;
                if (wr) drt[f] = 1;
            end
            else
            begin
                for (int i = 0; i < n; i++)
                    if (!found && !vld[i])
                    begin
                        found = 1; f = i;
                    end
                if (!found)
                begin
                    if (pol == POL_RANDOM)
                    begin
                        lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                        f = lfsr % n;
                    end
                    else if (pol == POL_CLOCK)
                    begin
                        h = (hand < n) ? hand : 0;
                        while (rfb[h])
                        begin
                            rfb[h] = 0;
                            h = (h + 1 < n) ? h + 1 : 0;
                        end
                        hand = (h + 1 < n) ? h + 1 : 0;
                        f = h;
                    end
                    else
                    begin
                        f = 0;
                        for (int i = 1; i < n; i++)
                            if (stp[i] < stp[f]) f = i;
                    end
                    r.evicted = 1;
                    r.evicted_page = pg[f];
                    r.writeback = drt[f];
                end
                pg[f] = page; vld[f] = 1; drt[f] = wr; rfb[f] = 1;
                stp[f] = stamp_ctr; stamp_ctr++;
            end
            r.frame_index = f[3:0];
            pending.push_back(r);
        endfunction

        function void check_result(access_result_t got);
            access_result_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word hit=%0b frame=%0d", $time,
                         got.hit, got.frame_index);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.hit !== exp_r.hit ||
                got.frame_index !== exp_r.frame_index ||
                got.evicted !== exp_r.evicted ||
                got.evicted_page !== exp_r.evicted_page ||
                got.writeback !== exp_r.writeback)
            begin
                $display("%0t: mismatch expected hit=%0b frame=%0d ev=%0b page=%h wb=%0b",
                         $time, exp_r.hit, exp_r.frame_index, exp_r.evicted,
                         exp_r.evicted_page, exp_r.writeback);
                $display("%0t:          actual   hit=%0b frame=%0d ev=%0b page=%h wb=%0b",
                         $time, got.hit, got.frame_index, got.evicted,
                         got.evicted_page, got.writeback);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [PAGE_W-1:0]      access_page;
    logic                   is_write;
    logic                   out_valid;
    logic                   out_stall;
    logic                   hit;
    logic [FIDX_W-1:0]      frame_index;
    logic                   evicted;
    logic [PAGE_W-1:0]      evicted_page;
    logic                   writeback;

    frame_table_scoreboard sb;
    int unsigned cycles;
    bit idle_on;

    page_frame_replacement uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .access_page(access_page), .is_write(is_write),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .frame_index(frame_index), .evicted(evicted),
        .evicted_page(evicted_page), .writeback(writeback)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_POLICY;
        cfg_data = '0;
        in_valid = 1'b0;
        access_page = '0;
        is_write = 1'b0;
        out_stall = 1'b0;
        idle_on = 1'b1;
        cycles = 0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** page_frame_replacement: FAILED **");
            $finish;
        end
    end

    // Receiver: random stall, check accepted words
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{hit, frame_index, evicted, evicted_page, writeback});
        out_stall <= idle_on && ($urandom_range(99) < 22);
    end

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, drain the block, then allow its longest latency
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Hold valid after an accept; the next word or wait_idle replaces it
    task automatic send_word(logic [PAGE_W-1:0] page, logic wr);
        while (idle_on && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        access_page <= page;
        is_write <= wr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_access(page, wr);
    endtask

    task automatic run_phase(int count, int span, bit wide);
        logic [PAGE_W-1:0] p;
        for (int k = 0; k < count; k++)
        begin
            if (wide && $urandom_range(9) == 0)
                p = PAGE_W'($urandom());
            else
                p = PAGE_W'($urandom_range(span - 1)) ^ (wide ? 20'hA5A5A : 20'h0);
            send_word(p, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        int plen;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, fills, hits, evictions in reset mode
        send_word(20'h00000, 1'b0);
        send_word(20'hFFFFF, 1'b1);
        send_word(20'h00000, 1'b1);
        send_word(20'hFFFFF, 1'b0);
        for (int i = 0; i < 18; i++)
            send_word(PAGE_W'(i * 4097), i[0]);
        wait_idle();

        // Random policy with zero frame count and zero seed, then clock policy with frame count 31
        write_reg(CFG_FRAMES, 16'd0);
        write_reg(CFG_POLICY, 16'(POL_RANDOM));
        write_reg(CFG_SEED, 16'd0);
        run_phase(6, 4, 0);
        wait_idle();
        write_reg(CFG_SPARE, 16'hFFFF);
        write_reg(CFG_SEED, 16'hFFFF);
        write_reg(CFG_FRAMES, 16'd31);
        write_reg(CFG_POLICY, 16'(POL_CLOCK));
        run_phase(12, 24, 0);
        wait_idle();

        // Random phases over policy, frame count and seed
        for (int ph = 0; ph < 24; ph++)
        begin
            write_reg(CFG_POLICY, 16'($urandom_range(3)));
            case ($urandom_range(3))
                0: write_reg(CFG_FRAMES, 16'd1);
                1: write_reg(CFG_FRAMES, 16'd16);
                default: write_reg(CFG_FRAMES, 16'($urandom_range(31)));
            endcase
            if ($urandom_range(2) == 0)
                write_reg(CFG_SEED, 16'($urandom_range(65535, 1)));
            idle_on = (ph != 12);
            plen = 50;
            run_phase(plen, $urandom_range(40, 3), $urandom_range(3) == 0);
            wait_idle();
        end
        idle_on = 1'b1;

        if (sb.errors == 0)
            $display("** page_frame_replacement: PASSED **");
        else
            $display("** page_frame_replacement: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

>>> page_frame_replacement.f
rtl/core/pfr_pkg.sv
rtl/core/pfr_cell.sv
rtl/core/pfr_rem.sv
rtl/core/page_frame_replacement.sv
dv/page_frame_replacement_tb.sv
